/* src/key_debouncer_with_layer_latch_top_assert.svh */
// Assertion macros shared by the key debouncer RTL.
`ifndef KEY_DEBOUNCER_WITH_LAYER_LATCH_TOP_ASSERT_SVH
`define KEY_DEBOUNCER_WITH_LAYER_LATCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KDL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("KDL assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define KDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("KDL assertion failed: next-cycle implication");

`endif

/* src/kdl_pkg.sv */
// Package with the shared types and constants of the key debouncer.
package kdl_pkg;

    localparam int NUM_KEYS_DEF = 64;
    localparam int HIST_W       = 16;
    localparam int LAYER_W      = 8;
    localparam int KEY_W        = 6;
    localparam int CMD_W        = 2;
    localparam int KEY_CMP_W    = 9;
    localparam logic [HIST_W-1:0] MASK_RESET = 16'h001F;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_RAISE  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [HIST_W-1:0]  hist;
        logic               pressed;
        logic [LAYER_W-1:0] layer;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [LAYER_W-1:0] active_layer;
        logic               newly_released;
        logic               newly_pressed;
        logic [LAYER_W-1:0] press_layer;
        logic               debounced_pressed;
    } result_t;

endpackage

/* src/kdl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module kdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/key_debouncer_with_layer_latch_top.sv */
// Top level of the per-key shift-register debouncer with layer latching.
// The block takes one transfer per clock unless the output stalls, and returns one
// registered result transfer per input transfer; the single read-modify-write of the
// key table sets this rate, and a write to a key that is read on the same edge is
// forwarded. Key state lives in one RAM of NUM_KEYS entries (history, debounced flag,
// latched layer); a valid bit per entry, cleared at reset, makes an unwritten entry
// read as zero, so there is no clearing pass after reset. Indexes at or above
// NUM_KEYS report zeros for the key fields. Write the debounce mask through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce this.
`include "key_debouncer_with_layer_latch_top_assert.svh"

module key_debouncer_with_layer_latch_top #(
    parameter int NUM_KEYS = kdl_pkg::NUM_KEYS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [kdl_pkg::HIST_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0: key_index[5:0], raw_pressed[6], layer_value[14:7], zero[15].
    input  logic [15:0]               s_tdata,
    // Fields from bit 0: command[1:0].
    input  logic [kdl_pkg::CMD_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0: debounced_pressed[0], press_layer[8:1], newly_pressed[9],
    // newly_released[10], active_layer[18:11], zero[23:19].
    output logic [23:0]               m_tdata
);

    import kdl_pkg::*;

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_CMP_W-1:0] KEY_LIMIT = KEY_CMP_W'(NUM_KEYS);

    logic [HIST_W-1:0]    mask_reg;
    logic [LAYER_W-1:0]   layer_reg, layer_next;
    logic [NUM_KEYS-1:0]  evld_reg;

    logic                 s1_valid_reg;
    logic [CMD_W-1:0]     s1_cmd_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic                 s1_kvalid_reg;
    logic                 s1_raw_reg;
    logic [LAYER_W-1:0]   s1_lv_reg;
    logic                 s1_fwd_reg, s1_fwd_next;
    logic                 s1_evld_reg;
    entry_t               fwd_data_reg;

    logic                 out_valid_reg;
    result_t              out_reg, out_next;

    logic [KEY_CMP_W-1:0] key_ext;
    logic [AW-1:0]        s_addr;
    logic                 s_kvalid;
    logic                 s_acc;
    logic                 s1_adv;

    entry_t               ram_rdata;
    entry_t               cur;
    entry_t               upd;
    logic                 ram_we;
    logic [HIST_W-1:0]    hist_new;
    logic [HIST_W-1:0]    sel;

    assign key_ext  = KEY_CMP_W'(s_tdata[KEY_W-1:0]);
    assign s_addr   = key_ext[AW-1:0];
    assign s_kvalid = key_ext < KEY_LIMIT;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;

    kdl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_KEYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (upd),
        .re    (s_acc),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur = s1_fwd_reg ? fwd_data_reg : (s1_evld_reg ? ram_rdata : '0);
        hist_new   = {cur.hist[HIST_W-2:0], s1_raw_reg};
        sel        = hist_new & mask_reg;
        upd        = cur;
        layer_next = layer_reg;
        out_next   = '0;
        ram_we     = 1'b0;
        unique case (s1_cmd_reg)
            CMD_SAMPLE:
            begin
                if (s1_kvalid_reg)
                begin
                    ram_we   = s1_adv;
                    upd.hist = hist_new;
                    if (!cur.pressed)
                    begin
                        if (sel == mask_reg)
                        begin
                            upd.pressed            = 1'b1;
                            upd.layer              = layer_reg;
                            out_next.newly_pressed = 1'b1;
                        end
                    end
                    else if (sel == '0)
                    begin
                        upd.pressed             = 1'b0;
                        out_next.newly_released = 1'b1;
                    end
                end
            end
            CMD_RAISE:
            begin
                if (s1_lv_reg > layer_reg)
                begin
                    layer_next = s1_lv_reg;
                end
            end
            CMD_CLEAR:
            begin
                layer_next = '0;
            end
            default:
            begin
                layer_next = layer_reg;
            end
        endcase
        if (s1_kvalid_reg)
        begin
            out_next.debounced_pressed = upd.pressed;
            out_next.press_layer       = upd.layer;
        end
        out_next.active_layer = layer_next;
    end

    always_comb
    begin
        if (s_acc)
        begin
            s1_fwd_next = ram_we && (s1_addr_reg == s_addr);
        end
        else if (s1_adv)
        begin
            s1_fwd_next = 1'b0;
        end
        else
        begin
            s1_fwd_next = s1_fwd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= MASK_RESET;
            layer_reg     <= '0;
            evld_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (s1_adv)
            begin
                layer_reg <= layer_next;
            end
            if (ram_we)
            begin
                evld_reg[s1_addr_reg] <= 1'b1;
            end
            if (s_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            s1_fwd_reg <= s1_fwd_next;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_cmd_reg    <= s_tuser;
            s1_addr_reg   <= s_addr;
            s1_kvalid_reg <= s_kvalid;
            s1_raw_reg    <= s_tdata[KEY_W];
            s1_lv_reg     <= s_tdata[KEY_W+LAYER_W:KEY_W+1];
            s1_evld_reg   <= evld_reg[s_addr];
        end
        if (ram_we)
        begin
            fwd_data_reg <= upd;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg};

    `KDL_ASSERT_IMPL(a_edge_excl, clk, rst_n, out_valid_reg,
        !(out_reg.newly_pressed && out_reg.newly_released))
    `KDL_ASSERT_IMPL(a_press_state, clk, rst_n, out_valid_reg && out_reg.newly_pressed,
        out_reg.debounced_pressed)
    `KDL_ASSERT_IMPL(a_release_state, clk, rst_n, out_valid_reg && out_reg.newly_released,
        !out_reg.debounced_pressed)
    `KDL_ASSERT_IMPL(a_write_adv, clk, rst_n, ram_we, s1_adv && s1_kvalid_reg)
    `KDL_ASSERT_IMPL(a_fwd_live, clk, rst_n, s1_fwd_reg, s1_valid_reg)
    `KDL_ASSERT_NEXT(a_write_marks, clk, rst_n, ram_we, evld_reg[$past(s1_addr_reg)])

endmodule
